@@ rtl/core/spte_pkg.sv @@
`timescale 1ns / 1ps
// Shared constants and types for the shortest path tree engine.
// Used by the compare-add unit and the top level; depends on nothing.
package spte_pkg;

   localparam int NODES       = 16;
   localparam int WEIGHT_BITS = 16;
   localparam int NODE_BITS   = (NODES > 1) ? $clog2(NODES) : 1;
   localparam int PAIR_BITS   = 2 * NODE_BITS;
   localparam int PAIR_DEPTH  = 1 << PAIR_BITS;
   localparam int DIST_BITS   = 20;
   localparam int SUM_BITS    = ((WEIGHT_BITS > DIST_BITS) ? WEIGHT_BITS : DIST_BITS) + 1;
   localparam int REPORT_MAX  = 16;
   localparam int REPORT      = (NODES < REPORT_MAX) ? NODES : REPORT_MAX;

   localparam logic [DIST_BITS-1:0] DIST_MAX = '1;

   localparam logic KIND_ADD = 1'b0;
   localparam logic KIND_RUN = 1'b1;

   typedef struct packed {
      logic [DIST_BITS-1:0]   base;
      logic [WEIGHT_BITS-1:0] addend;
      logic [DIST_BITS-1:0]   limit;
   } spte_alu_req_type;

   typedef struct packed {
      logic [DIST_BITS-1:0] sum;
      logic                 less;
   } spte_alu_rsp_type;

endpackage

@@ rtl/core/shortest_path_tree_engine_top.sv @@
`timescale 1ns / 1ps
// Shortest path tree engine: a run alternates a select pass over all NODES nodes with a
// relax pass over all nodes for each reachable node, ends with a select pass that finds none,
// then gives one result per cycle while rsp_stall is low. A run is limited by the one
// compare-add unit and the single read port of the weight RAM.
// Reset clears the edge-present bits and the sequencer at once; there is no clearing pass.
// Depends on spte_pkg, spte_ram and spte_alu.
module shortest_path_tree_engine_top
   import spte_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic                 req_kind,
   input  logic [3:0]           req_node_a,
   input  logic [3:0]           req_node_b,
   input  logic [15:0]          req_weight,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [3:0]           rsp_node,
   output logic                 rsp_reachable,
   output logic [DIST_BITS-1:0] rsp_distance,
   output logic [3:0]           rsp_parent,
   output logic                 rsp_last
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SELECT,
      ST_RELAX,
      ST_OUT
   } state_type;

   localparam logic [NODE_BITS-1:0] LAST_NODE   = NODE_BITS'(NODES - 1);
   localparam logic [NODE_BITS-1:0] LAST_REPORT = NODE_BITS'(REPORT - 1);
   localparam logic [NODE_BITS-1:0] ONE_NODE    = NODE_BITS'(1);

   state_type              state_ff;
   logic [NODE_BITS-1:0]   cnt_ff;
   logic [NODE_BITS-1:0]   u_ff;
   logic [NODE_BITS-1:0]   v_ff;
   logic                   found_ff;
   logic                   issue_ff;
   logic                   rv_ff;
   logic                   pres_rd_ff;
   logic [DIST_BITS-1:0]   best_ff;
   logic [DIST_BITS-1:0]   du_ff;
   logic [NODES-1:0]       reached_ff;
   logic [NODES-1:0]       settled_ff;
   logic [DIST_BITS-1:0]   dist_ff [NODES];
   logic [NODE_BITS-1:0]   parent_ff [NODES];
   logic [PAIR_DEPTH-1:0]  present_ff;

   logic                   rsp_valid_ff;
   logic [3:0]             rsp_node_ff;
   logic                   rsp_reachable_ff;
   logic [DIST_BITS-1:0]   rsp_distance_ff;
   logic [3:0]             rsp_parent_ff;
   logic                   rsp_last_ff;

   logic                   req_fire;
   logic                   edge_ok;
   logic                   src_ok;
   logic [NODE_BITS-1:0]   node_a_idx;
   logic [NODE_BITS-1:0]   node_b_idx;
   logic [PAIR_BITS-1:0]   edge_addr;
   logic [PAIR_BITS-1:0]   scan_addr;
   logic [NODE_BITS-1:0]   rd_idx;
   logic [DIST_BITS-1:0]   rd_dist;
   logic [NODE_BITS-1:0]   rd_parent;
   logic                   rd_reached;
   logic                   take;
   logic                   relax_hit;
   logic                   rsp_load;
   logic                   ram_wr_en;
   logic                   ram_rd_en;
   logic [WEIGHT_BITS-1:0] ram_rd_data;
   spte_alu_req_type       alu_req;
   spte_alu_rsp_type       alu_rsp;

   always_comb begin
      req_fire   = req_valid && !req_stall;
      src_ok     = (int'(req_node_a) < NODES);
      edge_ok    = src_ok && (int'(req_node_b) < NODES);
      node_a_idx = NODE_BITS'(req_node_a);
      node_b_idx = NODE_BITS'(req_node_b);
      edge_addr  = (node_a_idx <= node_b_idx) ? {node_a_idx, node_b_idx}
                                              : {node_b_idx, node_a_idx};
      scan_addr  = (u_ff <= cnt_ff) ? {u_ff, cnt_ff} : {cnt_ff, u_ff};
      rd_idx     = (state_ff == ST_RELAX) ? v_ff : cnt_ff;
      rd_dist    = dist_ff[rd_idx];
      rd_parent  = parent_ff[rd_idx];
      rd_reached = reached_ff[rd_idx];

      if (state_ff == ST_RELAX) begin
         alu_req.base   = du_ff;
         alu_req.addend = ram_rd_data;
         alu_req.limit  = rd_dist;
      end else begin
         alu_req.base   = rd_dist;
         alu_req.addend = '0;
         alu_req.limit  = best_ff;
      end

      take      = rd_reached && !settled_ff[rd_idx] && (!found_ff || alu_rsp.less);
      relax_hit = rv_ff && pres_rd_ff && (!rd_reached || alu_rsp.less);
      rsp_load  = (state_ff == ST_OUT) && (!rsp_valid_ff || !rsp_stall);
      ram_wr_en = req_fire && (req_kind == KIND_ADD) && edge_ok;
      ram_rd_en = (state_ff == ST_RELAX) && issue_ff;
   end

   spte_ram #(
      .WIDTH (WEIGHT_BITS),
      .DEPTH (PAIR_DEPTH)
   ) u_weight_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (edge_addr),
      .wr_data (WEIGHT_BITS'(req_weight)),
      .rd_en   (ram_rd_en),
      .rd_addr (scan_addr),
      .rd_data (ram_rd_data)
   );

   spte_alu u_alu (
      .alu_req (alu_req),
      .alu_rsp (alu_rsp)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         found_ff     <= 1'b0;
         issue_ff     <= 1'b0;
         rv_ff        <= 1'b0;
         reached_ff   <= '0;
         settled_ff   <= '0;
         present_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rv_ff <= 1'b0;
         if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (req_fire) begin
                  if (req_kind == KIND_ADD) begin
                     if (edge_ok) begin
                        present_ff[edge_addr] <= 1'b1;
                     end
                  end else begin
                     settled_ff <= '0;
                     found_ff   <= 1'b0;
                     cnt_ff     <= '0;
                     reached_ff <= '0;
                     if (src_ok) begin
                        reached_ff[node_a_idx] <= 1'b1;
                        dist_ff[node_a_idx]    <= '0;
                        parent_ff[node_a_idx]  <= node_a_idx;
                        state_ff               <= ST_SELECT;
                     end else begin
                        state_ff <= ST_OUT;
                     end
                  end
               end
            end
            ST_SELECT: begin
               if (take) begin
                  found_ff <= 1'b1;
                  u_ff     <= cnt_ff;
                  best_ff  <= rd_dist;
               end
               if (cnt_ff == LAST_NODE) begin
                  cnt_ff   <= '0;
                  found_ff <= 1'b0;
                  if (take || found_ff) begin
                     settled_ff[take ? cnt_ff : u_ff] <= 1'b1;
                     du_ff    <= take ? rd_dist : best_ff;
                     issue_ff <= 1'b1;
                     state_ff <= ST_RELAX;
                  end else begin
                     state_ff <= ST_OUT;
                  end
               end else begin
                  cnt_ff <= cnt_ff + ONE_NODE;
               end
            end
            ST_RELAX: begin
               if (issue_ff) begin
                  pres_rd_ff <= present_ff[scan_addr];
                  v_ff       <= cnt_ff;
                  rv_ff      <= 1'b1;
                  if (cnt_ff == LAST_NODE) begin
                     issue_ff <= 1'b0;
                     cnt_ff   <= '0;
                  end else begin
                     cnt_ff <= cnt_ff + ONE_NODE;
                  end
               end
               if (relax_hit) begin
                  reached_ff[v_ff] <= 1'b1;
                  dist_ff[v_ff]    <= alu_rsp.sum;
                  parent_ff[v_ff]  <= u_ff;
               end
               if (rv_ff && (v_ff == LAST_NODE)) begin
                  state_ff <= ST_SELECT;
               end
            end
            ST_OUT: begin
               if (rsp_load) begin
                  rsp_valid_ff     <= 1'b1;
                  rsp_node_ff      <= 4'(cnt_ff);
                  rsp_reachable_ff <= rd_reached;
                  rsp_distance_ff  <= rd_reached ? rd_dist : '0;
                  rsp_parent_ff    <= rd_reached ? 4'(rd_parent) : 4'(cnt_ff);
                  rsp_last_ff      <= (cnt_ff == LAST_REPORT);
                  if (cnt_ff == LAST_REPORT) begin
                     cnt_ff   <= '0;
                     state_ff <= ST_IDLE;
                  end else begin
                     cnt_ff <= cnt_ff + ONE_NODE;
                  end
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign req_stall     = (state_ff != ST_IDLE);
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_node      = rsp_node_ff;
   assign rsp_reachable = rsp_reachable_ff;
   assign rsp_distance  = rsp_distance_ff;
   assign rsp_parent    = rsp_parent_ff;
   assign rsp_last      = rsp_last_ff;

`ifndef SYNTHESIS
   // A run transfer hands control to the sequencer on the next cycle.
   a_run_starts: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && (req_kind == KIND_RUN) |=> req_stall)
      else $error("run transfer did not start the sequencer");

   // Relax data only arrives while the relax pass is active.
   a_relax_aligned: assert property (@(posedge clock) disable iff (reset)
      rv_ff |-> (state_ff == ST_RELAX))
      else $error("weight read returned outside the relax pass");

   // The node being relaxed has already been settled.
   a_relax_settled: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RELAX) |-> settled_ff[u_ff])
      else $error("relaxing from a node that is not settled");

   // Once the last result is loaded the output pass has finished.
   a_last_ends_run: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_last_ff |-> (state_ff != ST_OUT))
      else $error("output pass continued after the last result");
`endif

endmodule

@@ rtl/core/spte_ram.sv @@
`timescale 1ns / 1ps
// Generic single-port-write, single-port-read RAM with a registered read.
// Stands alone; holds the edge weights of the shortest path tree engine.
module spte_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/core/spte_alu.sv @@
`timescale 1ns / 1ps
// Shared saturating compare-add unit: adds a weight to a distance and
// compares the result with a limit. Depends on spte_pkg.
module spte_alu
   import spte_pkg::*;
(
   input  spte_alu_req_type alu_req,
   output spte_alu_rsp_type alu_rsp
);

   logic [SUM_BITS-1:0]  raw_sum;
   logic [DIST_BITS-1:0] sat_sum;

   always_comb begin
      raw_sum = SUM_BITS'(alu_req.base) + SUM_BITS'(alu_req.addend);
      if (raw_sum > SUM_BITS'(DIST_MAX)) begin
         sat_sum = DIST_MAX;
      end else begin
         sat_sum = raw_sum[DIST_BITS-1:0];
      end
      alu_rsp.sum  = sat_sum;
      alu_rsp.less = (sat_sum < alu_req.limit);
   end

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for the shortest path tree engine: it loads edges, starts runs and
// checks every node result against its own shortest path prediction, with random idling.
// Depends on spte_pkg and shortest_path_tree_engine_top.
module tb;
   import spte_pkg::*;

   localparam int CYCLE_LIMIT = 500000;
   localparam int DRAIN_CYCLES = 600;

   typedef struct packed {
      logic [3:0]           node;
      logic                 reachable;
      logic [DIST_BITS-1:0] distance;
      logic [3:0]           parent;
      logic                 last;
   } node_row_type;

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_stall;
   logic                 req_kind;
   logic [3:0]           req_node_a;
   logic [3:0]           req_node_b;
   logic [15:0]          req_weight;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   logic [3:0]           rsp_node;
   logic                 rsp_reachable;
   logic [DIST_BITS-1:0] rsp_distance;
   logic [3:0]           rsp_parent;
   logic                 rsp_last;

   logic [15:0]  link_weight [NODES][NODES];
   bit           link_on [NODES][NODES];
   node_row_type tree_rows [$];

   int mismatch_count = 0;
   int cycle_count = 0;
   int send_calm = 0;
   int stall_calm = 0;
   int hold_left = 0;

   shortest_path_tree_engine_top dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_kind      (req_kind),
      .req_node_a    (req_node_a),
      .req_node_b    (req_node_b),
      .req_weight    (req_weight),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_node      (rsp_node),
      .rsp_reachable (rsp_reachable),
      .rsp_distance  (rsp_distance),
      .rsp_parent    (rsp_parent),
      .rsp_last      (rsp_last)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   task automatic report_mismatch(input string what, input longint got, input longint want);
      $display("%0t: %s: got %0d, expected %0d", $time, what, got, want);
      mismatch_count++;
   endtask

   // Mostly random waits, with occasional stretches of back-to-back transfers.
   task automatic draw_gap(inout int calm, output int gap);
      if (calm > 0) begin
         calm--;
         gap = 0;
      end else if ($urandom_range(0, 15) == 0) begin
         calm = $urandom_range(5, 20);
         gap = 0;
      end else begin
         gap = $urandom_range(0, 10);
      end
   endtask

   function automatic logic [15:0] draw_weight();
      case ($urandom_range(0, 3))
         0: draw_weight = 16'($urandom_range(0, 7));
         1: draw_weight = 16'($urandom);
         2: draw_weight = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
         default: draw_weight = 16'($urandom_range(0, 255));
      endcase
   endfunction

   task automatic store_edge(input logic [3:0] a, input logic [3:0] b, input logic [15:0] w);
      link_weight[a][b] = w[WEIGHT_BITS-1:0];
      link_weight[b][a] = w[WEIGHT_BITS-1:0];
      link_on[a][b] = 1'b1;
      link_on[b][a] = 1'b1;
   endtask

   task automatic compute_tree(input logic [3:0] src);
      logic [DIST_BITS-1:0] node_dist [NODES];
      logic [3:0]           par [NODES];
      bit                   done [NODES];
      bit                   seen [NODES];
      bit                   found;
      int                   u;
      logic [DIST_BITS:0]   cand;
      node_row_type         row;
      for (int i = 0; i < NODES; i++) begin
         node_dist[i] = '0;
         par[i] = 4'(i);
         done[i] = 1'b0;
         seen[i] = 1'b0;
      end
      seen[src] = 1'b1;
      for (int step = 0; step < NODES; step++) begin
         found = 1'b0;
         u = 0;
         for (int i = 0; i < NODES; i++) begin
            if (seen[i] && !done[i] && (!found || node_dist[i] < node_dist[u])) begin
               u = i;
               found = 1'b1;
            end
         end
         if (!found) break;
         done[u] = 1'b1;
         for (int v = 0; v < NODES; v++) begin
            if (link_on[u][v]) begin
               cand = {1'b0, node_dist[u]} + link_weight[u][v];
               if (cand > {1'b0, DIST_MAX}) cand = {1'b0, DIST_MAX};
               if (!seen[v] || cand[DIST_BITS-1:0] < node_dist[v]) begin
                  seen[v] = 1'b1;
                  node_dist[v] = cand[DIST_BITS-1:0];
                  par[v] = 4'(u);
               end
            end
         end
      end
      for (int k = 0; k < REPORT; k++) begin
         row.node = 4'(k);
         row.reachable = seen[k];
         row.distance = seen[k] ? node_dist[k] : '0;
         row.parent = seen[k] ? par[k] : 4'(k);
         row.last = (k == REPORT - 1);
         tree_rows.push_back(row);
      end
   endtask

   task automatic send_item(input logic kind, input logic [3:0] a, input logic [3:0] b,
                            input logic [15:0] w);
      int gap;
      draw_gap(send_calm, gap);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_kind <= kind;
      req_node_a <= a;
      req_node_b <= b;
      req_weight <= w;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      if (kind == KIND_ADD) store_edge(a, b, w);
      else compute_tree(a);
   endtask

   task automatic test_isolated_source();
      send_item(KIND_RUN, 4'd0, 4'd0, 16'h0000);
      send_item(KIND_RUN, 4'd15, 4'd15, 16'hFFFF);
   endtask

   task automatic test_ties_and_special_edges();
      send_item(KIND_ADD, 4'd0, 4'd5, 16'd3);
      send_item(KIND_ADD, 4'd5, 4'd4, 16'd2);
      send_item(KIND_ADD, 4'd4, 4'd0, 16'd5);
      send_item(KIND_ADD, 4'd0, 4'd0, 16'd1);
      send_item(KIND_ADD, 4'd10, 4'd11, 16'd0);
      send_item(KIND_RUN, 4'd0, 4'd9, 16'h1234);
      send_item(KIND_RUN, 4'd10, 4'd0, 16'hFFFF);
      send_item(KIND_ADD, 4'd5, 4'd0, 16'd7);
      send_item(KIND_RUN, 4'd5, 4'd15, 16'h0000);
   endtask

   task automatic test_long_chain();
      for (int i = 15; i > 5; i--) send_item(KIND_ADD, 4'(i), 4'(i - 1), 16'hFFFF);
      send_item(KIND_RUN, 4'd15, 4'd3, 16'hA5A5);
   endtask

   task automatic test_random_graphs();
      int sent;
      int edges;
      sent = 0;
      while (sent < 88) begin
         edges = $urandom_range(0, 6);
         repeat (edges) begin
            send_item(KIND_ADD, 4'($urandom), 4'($urandom), draw_weight());
            sent++;
         end
         send_item(KIND_RUN, 4'($urandom), 4'($urandom), 16'($urandom));
         sent++;
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) draw_gap(stall_calm, hold_left);
      else if (hold_left > 0) hold_left--;
      rsp_stall <= (hold_left > 0);
   end

   always @(posedge clock) begin : check_rows
      node_row_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (tree_rows.size() == 0) begin
            report_mismatch("result with none expected, node", rsp_node, -1);
         end else begin
            want = tree_rows.pop_front();
            if (rsp_node !== want.node)
               report_mismatch("node", rsp_node, want.node);
            if (rsp_reachable !== want.reachable)
               report_mismatch("reachable", rsp_reachable, want.reachable);
            if (rsp_distance !== want.distance)
               report_mismatch("distance", rsp_distance, want.distance);
            if (rsp_parent !== want.parent)
               report_mismatch("parent", rsp_parent, want.parent);
            if (rsp_last !== want.last)
               report_mismatch("last", rsp_last, want.last);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   initial begin
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_kind <= KIND_ADD;
      req_node_a <= 4'd0;
      req_node_b <= 4'd0;
      req_weight <= 16'h0000;
      for (int i = 0; i < NODES; i++)
         for (int j = 0; j < NODES; j++) link_on[i][j] = 1'b0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      test_isolated_source();
      test_ties_and_special_edges();
      test_long_chain();
      test_random_graphs();

      req_valid <= 1'b0;
      while (tree_rows.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

@@ files.f @@
rtl/core/spte_pkg.sv
rtl/core/spte_ram.sv
rtl/core/spte_alu.sv
rtl/core/shortest_path_tree_engine_top.sv
tb/tb.sv
